>>> design/vector4_dot_norm_lerp_unit_top_macros.svh
// assertion macros for the vector unit top level
`ifndef VECTOR4_DOT_NORM_LERP_UNIT_TOP_MACROS_SVH
`define VECTOR4_DOT_NORM_LERP_UNIT_TOP_MACROS_SVH

// implication checked every cycle outside reset
`define VDNL_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// property on the cycle after a condition, also during reset
`define VDNL_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

>>> design/vdnl_pkg.sv
// shared constants, types and helpers of the vector unit
`default_nettype none
package vdnl_pkg;
  localparam int CMP_W     = 16;
  localparam int FRAC_W    = 12;
  localparam int WGT_W     = 17;
  localparam int WGT_FRAC  = 16;
  localparam int DOT_W     = 2 * CMP_W + 2;
  localparam int MAG_W     = CMP_W + 1;
  localparam int RAD_W     = 2 * MAG_W;
  localparam int NUM_W     = CMP_W + FRAC_W;
  localparam int DVS_W     = MAG_W + FRAC_W;
  localparam int QUO_W     = FRAC_W + 1;
  localparam int PROD_W    = 2 * CMP_W;
  localparam int SQ_W      = 2 * CMP_W - 1;
  localparam int LRP_W     = CMP_W + WGT_W + 2;
  localparam int SUM_W     = LRP_W - WGT_FRAC;
  localparam int SQRT_STEPS = MAG_W;
  localparam int DIV_STEPS  = QUO_W;
  // stage where the root is ready, and last stage before the output register
  localparam int ROOT_STG  = 2 + SQRT_STEPS;
  localparam int LAST_STG  = ROOT_STG + DIV_STEPS;
  localparam int META_DLY  = LAST_STG - 2;
  localparam int MAG_DLY   = DIV_STEPS;

  localparam logic [1:0] OP_DOT  = 2'd0;
  localparam logic [1:0] OP_MAG  = 2'd1;
  localparam logic [1:0] OP_NORM = 2'd2;
  localparam logic [1:0] OP_LERP = 2'd3;

  typedef logic signed [CMP_W-1:0] cmp_t;
  typedef logic [MAG_W-1:0]        mag_t;
  typedef logic signed [DOT_W-1:0] dot_t;

  typedef struct packed {
    logic [1:0]              op;
    dot_t                    dot;
    logic [3:0][CMP_W-1:0]   lerp;
    logic [3:0][CMP_W-1:0]   a;
  } meta_t;

  // clamp a widened sum to the component range
  function automatic cmp_t sat_cmp(input logic signed [SUM_W-1:0] v);
    logic signed [SUM_W-1:0] hi;
    logic signed [SUM_W-1:0] lo;
    hi = SUM_W'((1 <<< (CMP_W - 1)) - 1);
    lo = -hi - SUM_W'(1);
    if (v > hi) return cmp_t'(hi);
    if (v < lo) return cmp_t'(lo);
    return v[CMP_W-1:0];
  endfunction
endpackage
`default_nettype wire

>>> design/vdnl_ifs.sv
// stream interfaces for the input and result channels
`default_nettype none
interface vdnl_in_if;
  logic                           valid;
  logic                           ready;
  logic [1:0]                     operation;
  logic signed [vdnl_pkg::CMP_W-1:0] a_x, a_y, a_z, a_w;
  logic signed [vdnl_pkg::CMP_W-1:0] b_x, b_y, b_z, b_w;
  logic [vdnl_pkg::WGT_W-1:0]     weight;
  modport source (output valid, operation, a_x, a_y, a_z, a_w, b_x, b_y, b_z, b_w,
                  weight, input ready);
  modport sink (input valid, operation, a_x, a_y, a_z, a_w, b_x, b_y, b_z, b_w,
                weight, output ready);
endinterface

interface vdnl_out_if;
  logic                              valid;
  logic                              ready;
  logic signed [vdnl_pkg::CMP_W-1:0] r_x, r_y, r_z, r_w;
  logic signed [vdnl_pkg::DOT_W-1:0] dot_value;
  logic [vdnl_pkg::MAG_W-1:0]        magnitude;
  logic                              zero_vector;
  modport source (output valid, r_x, r_y, r_z, r_w, dot_value, magnitude, zero_vector,
                  input ready);
  modport sink (input valid, r_x, r_y, r_z, r_w, dot_value, magnitude, zero_vector,
                output ready);
endinterface
`default_nettype wire

>>> design/vector4_dot_norm_lerp_unit_top.sv
// Four-component Q4.12 vector unit: dot product, magnitude, normalize, lerp.
// in_ch carries an operation code, vectors a and b and a Q1.16 weight; out_ch
// carries one result transaction per input transaction, in order.
// Both channels use valid/ready; a transaction moves when both are high.
// Throughput: one transaction per cycle while the output is not stalled.
// A transaction passes through two lane stages, 17 square root stages (one root bit
// each) and 13 divider stages (one quotient bit each) plus the output register.
// A zero vector normalizes to zeros and raises zero_vector.
// The whole pipeline advances together: it moves whenever the output register
// is empty or being taken, so in_ch.ready drops only while a finished result
// waits and the receiver holds out_ch.ready low.
// Synchronous active-low reset empties the pipeline; no result is valid after.
`default_nettype none
module vector4_dot_norm_lerp_unit_top (
  input wire logic   clk,
  input wire logic   rst_n,
  vdnl_in_if.sink    in_ch,
  vdnl_out_if.source out_ch
);
  import vdnl_pkg::*;

  logic                    en;
  logic [LAST_STG:1]       vld_r;
  logic                    out_valid_r;
  cmp_t                    a_in   [4];
  cmp_t                    b_in   [4];
  logic signed [PROD_W-1:0] prod_ab [4];
  logic [SQ_W-1:0]         prod_aa [4];
  cmp_t                    lerp   [4];
  logic [1:0]              op1_r, op2_r;
  logic [3:0][CMP_W-1:0]   a1_r, a2_r;
  dot_t                    dot_r;
  logic [RAD_W-1:0]        sumsq_r;
  meta_t                   meta0;
  meta_t                   meta_r [1:META_DLY];
  mag_t                    root;
  mag_t                    mag_r  [1:MAG_DLY];
  logic [QUO_W-1:0]        quo    [4];
  cmp_t                    r_nxt  [4];
  cmp_t                    r_r    [4];
  dot_t                    dot_nxt, dot_out_r;
  mag_t                    mag_nxt, mag_out_r;
  logic                    zero_nxt, zero_out_r;
  meta_t                   mfin;
  mag_t                    mfin_mag;

  assign en          = !out_valid_r || out_ch.ready;
  assign in_ch.ready = en;

  assign a_in[0] = in_ch.a_x;
  assign a_in[1] = in_ch.a_y;
  assign a_in[2] = in_ch.a_z;
  assign a_in[3] = in_ch.a_w;
  assign b_in[0] = in_ch.b_x;
  assign b_in[1] = in_ch.b_y;
  assign b_in[2] = in_ch.b_z;
  assign b_in[3] = in_ch.b_w;

  // valid bits follow the pipeline
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r       <= '0;
      out_valid_r <= 1'b0;
    end else if (en) begin
      vld_r       <= {vld_r[LAST_STG-1:1], in_ch.valid};
      out_valid_r <= vld_r[LAST_STG];
    end
  end

  // component lanes
  for (genvar i = 0; i < 4; i++) begin : g_lane
    vdnl_lane u_lane (
      .clk     (clk),
      .en      (en),
      .a       (a_in[i]),
      .b       (b_in[i]),
      .weight  (in_ch.weight),
      .prod_ab (prod_ab[i]),
      .prod_aa (prod_aa[i]),
      .lerp    (lerp[i])
    );
  end

  // merge: sums of the lane products
  always_ff @(posedge clk) begin
    if (en) begin
      op1_r   <= in_ch.operation;
      a1_r    <= {a_in[3], a_in[2], a_in[1], a_in[0]};
      op2_r   <= op1_r;
      a2_r    <= a1_r;
      dot_r   <= DOT_W'(prod_ab[0]) + DOT_W'(prod_ab[1])
               + DOT_W'(prod_ab[2]) + DOT_W'(prod_ab[3]);
      sumsq_r <= RAD_W'(prod_aa[0]) + RAD_W'(prod_aa[1])
               + RAD_W'(prod_aa[2]) + RAD_W'(prod_aa[3]);
    end
  end

  assign meta0.op   = op2_r;
  assign meta0.dot  = dot_r;
  assign meta0.lerp = {lerp[3], lerp[2], lerp[1], lerp[0]};
  assign meta0.a    = a2_r;

  // side data delay line up to the output stage
  always_ff @(posedge clk) begin
    if (en) begin
      meta_r[1] <= meta0;
      for (int k = 2; k <= META_DLY; k++) meta_r[k] <= meta_r[k-1];
      mag_r[1] <= root;
      for (int k = 2; k <= MAG_DLY; k++) mag_r[k] <= mag_r[k-1];
    end
  end

  vdnl_sqrt u_sqrt (
    .clk      (clk),
    .en       (en),
    .radicand (sumsq_r),
    .root     (root)
  );

  // per-component dividers for normalize
  for (genvar i = 0; i < 4; i++) begin : g_div
    logic [CMP_W-1:0] comp;
    logic [CMP_W-1:0] abs_c;
    assign comp  = meta_r[ROOT_STG-2].a[i];
    assign abs_c = comp[CMP_W-1] ? CMP_W'(-comp) : comp;
    vdnl_div u_div (
      .clk      (clk),
      .en       (en),
      .dividend ({abs_c, {FRAC_W{1'b0}}}),
      .divisor  (root),
      .quotient (quo[i])
    );
  end

  // result select per operation
  assign mfin     = meta_r[META_DLY];
  assign mfin_mag = mag_r[MAG_DLY];
  always_comb begin
    dot_nxt  = '0;
    mag_nxt  = '0;
    zero_nxt = 1'b0;
    for (int i = 0; i < 4; i++) r_nxt[i] = '0;
    unique case (mfin.op)
      OP_DOT: dot_nxt = mfin.dot;
      OP_MAG: mag_nxt = mfin_mag;
      OP_NORM: begin
        mag_nxt  = mfin_mag;
        zero_nxt = (mfin_mag == '0);
        if (mfin_mag != '0) begin
          for (int i = 0; i < 4; i++) begin
            r_nxt[i] = mfin.a[i][CMP_W-1] ? -cmp_t'(quo[i]) : cmp_t'(quo[i]);
          end
        end
      end
      OP_LERP: for (int i = 0; i < 4; i++) r_nxt[i] = mfin.lerp[i];
      default: dot_nxt = '0;
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 4; i++) r_r[i] <= r_nxt[i];
      dot_out_r  <= dot_nxt;
      mag_out_r  <= mag_nxt;
      zero_out_r <= zero_nxt;
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.r_x         = r_r[0];
  assign out_ch.r_y         = r_r[1];
  assign out_ch.r_z         = r_r[2];
  assign out_ch.r_w         = r_r[3];
  assign out_ch.dot_value   = dot_out_r;
  assign out_ch.magnitude   = mag_out_r;
  assign out_ch.zero_vector = zero_out_r;

  // checks
`include "vector4_dot_norm_lerp_unit_top_macros.svh"
  `VDNL_ASSERT_IMP(a_zero_clears, out_ch.valid && out_ch.zero_vector,
    out_ch.r_x == 0 && out_ch.r_y == 0 && out_ch.r_z == 0 && out_ch.r_w == 0,
    "zero vector with nonzero components")
  `VDNL_ASSERT_IMP(a_dot_excl, out_ch.valid && out_ch.dot_value != 0,
    out_ch.magnitude == 0 && !out_ch.zero_vector, "dot result mixed with other fields")
  `VDNL_ASSERT_IMP(a_stall_ready, out_ch.valid && !out_ch.ready, !in_ch.ready,
    "input taken while pipeline is stalled")
  `VDNL_ASSERT_NXT(a_reset_empty, !rst_n, !out_ch.valid, "result valid after reset")
endmodule
`default_nettype wire

>>> design/vdnl_lane.sv
// one component lane: products and the interpolated component
`default_nettype none
module vdnl_lane (
  input  wire logic                          clk,
  input  wire logic                          en,
  input  wire vdnl_pkg::cmp_t                a,
  input  wire vdnl_pkg::cmp_t                b,
  input  wire logic [vdnl_pkg::WGT_W-1:0]    weight,
  output logic signed [vdnl_pkg::PROD_W-1:0] prod_ab,
  output logic [vdnl_pkg::SQ_W-1:0]          prod_aa,
  output vdnl_pkg::cmp_t                     lerp
);
  import vdnl_pkg::*;

  logic signed [PROD_W-1:0] ab_r;
  logic signed [PROD_W-1:0] aa_r;
  logic signed [LRP_W-1:0]  dw_r;
  cmp_t                     a1_r;
  cmp_t                     lerp_r;
  logic signed [CMP_W:0]    diff;
  logic signed [LRP_W-1:0]  dw_adj;
  logic signed [SUM_W-1:0]  lerp_sum;

  // stage one: products
  assign diff = {b[CMP_W-1], b} - {a[CMP_W-1], a};
  always_ff @(posedge clk) begin
    if (en) begin
      ab_r <= a * b;
      aa_r <= a * a;
      dw_r <= diff * $signed({1'b0, weight});
      a1_r <= a;
    end
  end

  // stage two: scale toward zero, add, clamp
  assign dw_adj   = dw_r + (dw_r[LRP_W-1] ? LRP_W'((1 << WGT_FRAC) - 1) : LRP_W'(0));
  assign lerp_sum = {{(SUM_W-CMP_W){a1_r[CMP_W-1]}}, a1_r} + dw_adj[LRP_W-1:WGT_FRAC];
  always_ff @(posedge clk) begin
    if (en) lerp_r <= sat_cmp(lerp_sum);
  end

  assign prod_ab = ab_r;
  assign prod_aa = aa_r[SQ_W-1:0];
  assign lerp    = lerp_r;
endmodule
`default_nettype wire

>>> design/vdnl_sqrt.sv
// pipelined integer square root, one root bit per stage
`default_nettype none
module vdnl_sqrt (
  input  wire logic                       clk,
  input  wire logic                       en,
  input  wire logic [vdnl_pkg::RAD_W-1:0] radicand,
  output vdnl_pkg::mag_t                  root
);
  import vdnl_pkg::*;

  logic [RAD_W-1:0] x_r    [SQRT_STEPS];
  logic [MAG_W:0]   rem_r  [SQRT_STEPS];
  mag_t             root_r [SQRT_STEPS];

  for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_step
    logic [RAD_W-1:0] x_in;
    logic [MAG_W:0]   rem_in;
    mag_t             root_in;
    logic [MAG_W+2:0] cand;
    logic [MAG_W+2:0] trial;
    logic [MAG_W+2:0] diff;

    if (k == 0) begin : g_first
      assign x_in    = radicand;
      assign rem_in  = '0;
      assign root_in = '0;
    end else begin : g_next
      assign x_in    = x_r[k-1];
      assign rem_in  = rem_r[k-1];
      assign root_in = root_r[k-1];
    end

    // bring down two bits and try the next root bit
    assign cand  = {rem_in, x_in[RAD_W-1 -: 2]};
    assign trial = {1'b0, root_in, 2'b01};
    assign diff  = cand - trial;

    always_ff @(posedge clk) begin
      if (en) begin
        x_r[k] <= {x_in[RAD_W-3:0], 2'b00};
        if (cand >= trial) begin
          rem_r[k]  <= diff[MAG_W:0];
          root_r[k] <= {root_in[MAG_W-2:0], 1'b1};
        end else begin
          rem_r[k]  <= cand[MAG_W:0];
          root_r[k] <= {root_in[MAG_W-2:0], 1'b0};
        end
      end
    end
  end

  assign root = root_r[SQRT_STEPS-1];
endmodule
`default_nettype wire

>>> design/vdnl_div.sv
// pipelined restoring divider, one quotient bit per stage
`default_nettype none
module vdnl_div (
  input  wire logic                       clk,
  input  wire logic                       en,
  input  wire logic [vdnl_pkg::NUM_W-1:0] dividend,
  input  wire vdnl_pkg::mag_t             divisor,
  output logic [vdnl_pkg::QUO_W-1:0]      quotient
);
  import vdnl_pkg::*;

  logic [NUM_W-1:0] rem_r [DIV_STEPS];
  mag_t             dvs_r [DIV_STEPS];
  logic [QUO_W-1:0] quo_r [DIV_STEPS];

  for (genvar k = 0; k < DIV_STEPS; k++) begin : g_step
    logic [NUM_W-1:0] rem_in;
    mag_t             dvs_in;
    logic [QUO_W-1:0] quo_in;
    logic [DVS_W-1:0] trial;
    logic [DVS_W-1:0] diff;

    if (k == 0) begin : g_first
      assign rem_in = dividend;
      assign dvs_in = divisor;
      assign quo_in = '0;
    end else begin : g_next
      assign rem_in = rem_r[k-1];
      assign dvs_in = dvs_r[k-1];
      assign quo_in = quo_r[k-1];
    end

    // compare against the shifted divisor
    assign trial = {{FRAC_W{1'b0}}, dvs_in} << (DIV_STEPS - 1 - k);
    assign diff  = {{(DVS_W-NUM_W){1'b0}}, rem_in} - trial;

    always_ff @(posedge clk) begin
      if (en) begin
        dvs_r[k] <= dvs_in;
        if ({{(DVS_W-NUM_W){1'b0}}, rem_in} >= trial) begin
          rem_r[k] <= diff[NUM_W-1:0];
          quo_r[k] <= {quo_in[QUO_W-2:0], 1'b1};
        end else begin
          rem_r[k] <= rem_in;
          quo_r[k] <= {quo_in[QUO_W-2:0], 1'b0};
        end
      end
    end
  end

  assign quotient = quo_r[DIV_STEPS-1];
endmodule
`default_nettype wire
